// File: src/lgre_pkg.sv
// ----------------------------------------------------------------------------
// lgre_pkg
// shared types and constants for the life generation row engine
// ----------------------------------------------------------------------------
package lgre_pkg;

	localparam int ROW_CELLS = 64;
	localparam int WIDTH_BITS = 7;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

	localparam logic [3:0] BIRTH_COUNT = 4'd3;
	localparam logic [3:0] STAY_COUNT = 4'd2;

	// masked view of one column as its neighbors see it
	typedef struct packed {
		logic up;
		logic mid;
		logic dn;
	} lgre_col_t;

	typedef struct packed {
		logic [ROW_CELLS-1:0] next_row;
		logic                 frame_last;
	} lgre_res_t;

	function automatic logic lgre_rule(input logic alive, input logic [3:0] n);
		lgre_rule = (n == BIRTH_COUNT) || (alive && (n == STAY_COUNT));
	endfunction

endpackage

// File: src/lgre_cell.sv
// ----------------------------------------------------------------------------
// lgre_cell
// one grid column: holds its bit of the two buffered rows and computes the
// next state of that column for the middle row and for a closing last row
// ----------------------------------------------------------------------------
module lgre_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               last_row,
	input  logic               have_mid,
	input  logic               mask,
	input  logic               row_bit,
	input  lgre_pkg::lgre_col_t left,
	input  lgre_pkg::lgre_col_t right,
	output lgre_pkg::lgre_col_t own,
	output logic               res_a,
	output logic               res_b
);
	import lgre_pkg::*;

	logic above_q;
	logic mid_q;
	logic [3:0] n_a;
	logic [3:0] n_b;
	logic lu_b;
	logic ru_b;
	logic u_b;

	assign own.up  = above_q & mask;
	assign own.mid = mid_q & mask;
	assign own.dn  = row_bit & mask;

	// rows above/middle/below for the first result
	assign n_a = 4'(left.up) + 4'(own.up) + 4'(right.up)
		+ 4'(left.mid) + 4'(right.mid)
		+ 4'(left.dn) + 4'(own.dn) + 4'(right.dn);

	// closing row: middle becomes above, new row is middle, dead row below
	assign lu_b = have_mid & left.mid;
	assign u_b  = have_mid & own.mid;
	assign ru_b = have_mid & right.mid;
	assign n_b  = 4'(lu_b) + 4'(u_b) + 4'(ru_b) + 4'(left.dn) + 4'(right.dn);

	assign res_a = mask & lgre_rule(own.mid, n_a);
	assign res_b = mask & lgre_rule(own.dn, n_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q <= 1'b0;
			mid_q   <= 1'b0;
		end else if (accept) begin
			if (last_row) begin
				above_q <= 1'b0;
				mid_q   <= 1'b0;
			end else begin
				above_q <= have_mid & mid_q;
				mid_q   <= row_bit;
			end
		end
	end

endmodule

// File: src/lgre_outq.sv
// ----------------------------------------------------------------------------
// lgre_outq
// result queue taking up to two requests per cycle and giving one per cycle while res_stall is low
// ----------------------------------------------------------------------------
module lgre_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           push_n,
	input  lgre_pkg::lgre_res_t  push_a,
	input  lgre_pkg::lgre_res_t  push_b,
	output logic                 full,
	output logic                 res_valid,
	input  logic                 res_stall,
	output lgre_pkg::lgre_res_t  res
);
	import lgre_pkg::*;

	lgre_res_t mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic pop;

	assign res_valid = (count_q != '0);
	assign pop       = res_valid && !res_stall;
	assign res       = mem_q[rd_ptr_q];
	assign full      = (count_q > QCNT_BITS'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push_a;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + QPTR_BITS'(1)] <= push_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_BITS'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			count_q <= count_q + QCNT_BITS'(push_n) - QCNT_BITS'(pop);
		end
	end

endmodule

// File: src/life_generation_row_engine.sv
// ----------------------------------------------------------------------------
// life_generation_row_engine
// one b3/s23 generation over a bounded grid streamed one row per request
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  row      row_valid/row_stall    row_cells, last_row
//  res      res_valid/res_stall    next_row, frame_last
//  cfg      cfg_valid/cfg_ready    active_width
//
//  one row per cycle while row_stall is low; the column cells compute both
//  results in the accept cycle and the four-entry result queue shows them from the next cycle on
//  row_stall rises while fewer than two queue entries are free
//  reset clears the buffered rows, the pending-row flag and the queue, and
//  sets active_width to 64
// ----------------------------------------------------------------------------
module life_generation_row_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lgre_pkg::WIDTH_BITS-1:0]   active_width,
	input  logic                              row_valid,
	output logic                              row_stall,
	input  logic [lgre_pkg::ROW_CELLS-1:0]    row_cells,
	input  logic                              last_row,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [lgre_pkg::ROW_CELLS-1:0]    next_row,
	output logic                              frame_last
);
	import lgre_pkg::*;

	logic [WIDTH_BITS-1:0] width_q;
	logic have_mid_q;
	logic accept;
	logic full;
	logic [ROW_CELLS-1:0] mask;
	logic [ROW_CELLS-1:0] res_a;
	logic [ROW_CELLS-1:0] res_b;
	lgre_col_t cols [ROW_CELLS];
	lgre_col_t lefts [ROW_CELLS];
	lgre_col_t rights [ROW_CELLS];
	logic [1:0] push_n;
	lgre_res_t push_a;
	lgre_res_t push_b;
	lgre_res_t res;

	assign cfg_ready = 1'b1;
	assign row_stall = full;
	assign accept    = row_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_BITS'(ROW_CELLS);
		end else if (cfg_valid) begin
			width_q <= active_width;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_mid_q <= 1'b0;
		end else if (accept) begin
			have_mid_q <= !last_row;
		end
	end

	genvar j;
	generate
		for (j = 0; j < ROW_CELLS; j++) begin : g_col
			assign mask[j] = (WIDTH_BITS'(j) < width_q);

			if (j == 0) begin : g_l0
				assign lefts[j] = '0;
			end else begin : g_l
				assign lefts[j] = cols[j-1];
			end

			if (j == ROW_CELLS - 1) begin : g_rn
				assign rights[j] = '0;
			end else begin : g_r
				assign rights[j] = cols[j+1];
			end

			lgre_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.accept   (accept),
				.last_row (last_row),
				.have_mid (have_mid_q),
				.mask     (mask[j]),
				.row_bit  (row_cells[j]),
				.left     (lefts[j]),
				.right    (rights[j]),
				.own      (cols[j]),
				.res_a    (res_a[j]),
				.res_b    (res_b[j])
			);
		end
	endgenerate

	always_comb begin
		push_n = 2'd0;
		if (accept) begin
			push_n = 2'(have_mid_q) + 2'(last_row);
		end
		push_b.next_row   = res_b;
		push_b.frame_last = 1'b1;
		if (have_mid_q) begin
			push_a.next_row   = res_a;
			push_a.frame_last = 1'b0;
		end else begin
			push_a = push_b;
		end
	end

	lgre_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_a    (push_a),
		.push_b    (push_b),
		.full      (full),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	assign next_row   = res.next_row;
	assign frame_last = res.frame_last;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// testbench for the life generation row engine: grid rows are streamed in
// with random gaps and back-pressure, a local b3/s23 row predictor tracks the
// buffered rows and the active width, and every result row is compared in
// order against the predicted next generation
// ----------------------------------------------------------------------------
module tb_top;

	import lgre_pkg::*;

	localparam int RUN_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 4;
	localparam int REPORT_MAX = 10;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [WIDTH_BITS-1:0]   active_width = 7'd64;
	logic                    row_valid = 1'b0;
	logic                    row_stall;
	logic [ROW_CELLS-1:0]    row_cells = '0;
	logic                    last_row = 1'b0;
	logic                    res_valid;
	logic                    res_stall = 1'b0;
	logic [ROW_CELLS-1:0]    next_row;
	logic                    frame_last;

	// predictor state
	logic [WIDTH_BITS-1:0]   gen_width = 7'd64;
	logic [ROW_CELLS-1:0]    gen_above = '0;
	logic [ROW_CELLS-1:0]    gen_middle = '0;
	logic                    gen_have_mid = 1'b0;
	lgre_res_t               pending_gens[$];

	int mismatch_count = 0;
	int cycle_count = 0;
	int hold_req = 0;
	bit src_idle_on = 1'b1;
	bit sink_idle_on = 1'b1;

	life_generation_row_engine uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.active_width (active_width),
		.row_valid    (row_valid),
		.row_stall    (row_stall),
		.row_cells    (row_cells),
		.last_row     (last_row),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.next_row     (next_row),
		.frame_last   (frame_last)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_gens.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int cell_of(input logic [ROW_CELLS-1:0] r, input int j);
		if (j < 0 || j >= ROW_CELLS)
			return 0;
		return int'(r[j]);
	endfunction

	function automatic logic [ROW_CELLS-1:0] next_gen(input logic [ROW_CELLS-1:0] up,
		input logic [ROW_CELLS-1:0] mid, input logic [ROW_CELLS-1:0] dn);
		logic [ROW_CELLS-1:0] m;
		logic [ROW_CELLS-1:0] res;
		int n;
		m = (gen_width >= 7'd64) ? '1 : ((64'd1 << gen_width) - 64'd1);
		up &= m;
		mid &= m;
		dn &= m;
		res = '0;
		for (int j = 0; j < ROW_CELLS; j++) begin
			n = cell_of(up, j - 1) + cell_of(up, j) + cell_of(up, j + 1)
				+ cell_of(mid, j - 1) + cell_of(mid, j + 1)
				+ cell_of(dn, j - 1) + cell_of(dn, j) + cell_of(dn, j + 1);
			res[j] = (n == 3) || (mid[j] && n == 2);
		end
		return res & m;
	endfunction

	// advance the predictor by one accepted row
	task automatic predict_row(input logic [ROW_CELLS-1:0] cells, input logic is_last);
		if (gen_have_mid) begin
			pending_gens.push_back('{next_row: next_gen(gen_above, gen_middle, cells),
				frame_last: 1'b0});
			gen_above = gen_middle;
		end else begin
			gen_above = '0;
		end
		gen_middle = cells;
		gen_have_mid = 1'b1;
		if (is_last) begin
			pending_gens.push_back('{next_row: next_gen(gen_above, gen_middle, '0),
				frame_last: 1'b1});
			gen_above = '0;
			gen_middle = '0;
			gen_have_mid = 1'b0;
		end
	endtask

	// entered and left at a falling edge
	task automatic send_row(input logic [ROW_CELLS-1:0] cells, input logic is_last);
		int gap;
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			row_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		row_valid <= 1'b1;
		row_cells <= cells;
		last_row <= is_last;
		@(posedge clk);
		while (row_stall)
			@(posedge clk);
		predict_row(cells, is_last);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		row_valid <= 1'b0;
		while (pending_gens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_width(input logic [WIDTH_BITS-1:0] w);
		wait_drained();
		cfg_valid <= 1'b1;
		active_width <= w;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		gen_width = w;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [ROW_CELLS-1:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [ROW_CELLS-1:0] rand_row();
		logic [ROW_CELLS-1:0] r;
		case ($urandom_range(0, 6))
			0: r = rand_word() & rand_word() & rand_word();
			1: r = rand_word() | rand_word();
			2: r = 64'd7 << $urandom_range(0, 61);
			3: r = ($urandom_range(0, 1) == 0) ? '0 : '1;
			default: r = rand_word();
		endcase
		return r;
	endfunction

	function automatic logic [WIDTH_BITS-1:0] pick_width();
		case ($urandom_range(0, 7))
			0: return 7'd0;
			1: return 7'd1;
			2: return 7'd2;
			3: return 7'd64;
			4: return 7'd127;
			5: return 7'($urandom_range(65, 126));
			default: return 7'($urandom_range(3, 63));
		endcase
	endfunction

	// receiver stall: long hold-offs on request, otherwise random bursts
	initial begin
		int burst;
		int held;
		burst = 0;
		held = 0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				held = hold_req;
				hold_req = 0;
			end
			if (held > 0) begin
				held--;
				res_stall <= 1'b1;
			end else if (burst > 0) begin
				burst--;
				res_stall <= 1'b1;
			end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 15) - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		lgre_res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_gens.size() == 0) begin
				if (mismatch_count < REPORT_MAX)
					$display("%0t: unexpected result next_row=%h frame_last=%b",
						$time, next_row, frame_last);
				mismatch_count++;
			end else begin
				want = pending_gens.pop_front();
				if (want.next_row !== next_row || want.frame_last !== frame_last) begin
					if (mismatch_count < REPORT_MAX)
						$display("%0t: mismatch next_row exp=%h act=%h frame_last exp=%b act=%b",
							$time, want.next_row, next_row, want.frame_last, frame_last);
					mismatch_count++;
				end
			end
		end
	end

	task automatic test_single_row_frames();
		send_row('0, 1'b1);
		send_row('1, 1'b1);
		send_row(64'h5555_5555_5555_5555, 1'b1);
		send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
		send_row(64'h8000_0000_0000_0001, 1'b1);
	endtask

	task automatic test_known_patterns();
		// vertical blinker, then a glider against the high edge
		send_row('0, 1'b0);
		send_row(64'h8, 1'b0);
		send_row(64'h8, 1'b0);
		send_row(64'h8, 1'b0);
		send_row('0, 1'b1);
		send_row(64'h4000_0000_0000_0000, 1'b0);
		send_row(64'h8000_0000_0000_0000, 1'b0);
		send_row(64'hE000_0000_0000_0000, 1'b0);
		send_row('1, 1'b1);
	endtask

	task automatic test_width_extremes();
		write_width(7'd1);
		send_row('1, 1'b1);
		write_width(7'd0);
		send_row('1, 1'b1);
		write_width(7'd127);
		send_row('1, 1'b0);
		send_row(64'hF0F0_0F0F_F0F0_0F0F, 1'b1);
		write_width(7'd3);
		send_row(64'hF, 1'b0);
		send_row(64'h7, 1'b1);
	endtask

	task automatic test_width_mid_frame();
		write_width(7'd64);
		send_row(64'hFFFF, 1'b0);
		write_width(7'd8);
		send_row(64'hFFFF, 1'b0);
		send_row(64'hFFFF, 1'b1);
		write_width(7'd64);
	endtask

	task automatic test_random_frames(input int n_rows);
		int sent;
		int len;
		sent = 0;
		while (sent < n_rows) begin
			if ($urandom_range(0, 5) == 0)
				write_width(pick_width());
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
			for (int k = 0; k < len; k++)
				send_row(rand_row(), k == len - 1);
			sent += len;
		end
	endtask

	task automatic test_backpressure();
		src_idle_on = 1'b0;
		hold_req = 60;
		for (int k = 0; k < 24; k++)
			send_row(rand_row(), (k == 23) || ($urandom_range(0, 4) == 0));
		// sender waits for every result before going on
		wait_drained();
		src_idle_on = 1'b1;
	endtask

	task automatic test_full_rate();
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		test_random_frames(60);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_single_row_frames();
		test_known_patterns();
		test_width_extremes();
		test_width_mid_frame();
		test_random_frames(320);
		test_backpressure();
		test_full_rate();

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_gens.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
